### rtl/rmrd_pkg.sv
// Package for the radio module reply deframer.
// Holds frame marks, command and status codes and reset values; no dependencies.
package rmrd_pkg;

	localparam int DEF_MAX_PAYLOAD = 256;

	localparam int CMD_W      = 2;
	localparam int BYTE_W     = 8;
	localparam int STATUS_W   = 3;
	localparam int EVENT_W    = 9;
	localparam int LEN_W      = 16;
	localparam int POS_W      = 17;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 48;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// command codes
	localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_START = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_REFUSED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NO_EVENT = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EVENT_MODE = 1'd1;

	localparam logic [BYTE_W-1:0] MARK_START     = 8'hFE;
	localparam logic [BYTE_W-1:0] MARK_END       = 8'hFD;
	localparam logic [BYTE_W-1:0] EVENT_TYPE     = 8'h07;
	localparam logic [BYTE_W-1:0] REFUSE_SUBTYPE = 8'h02;
	localparam logic [POS_W-1:0]  POS_MAX        = '1;

	localparam logic [LEN_W-1:0] TIMEOUT_RESET = 16'd200;

	// header byte positions
	localparam logic [POS_W-1:0] POS_TYPE    = 17'd1;
	localparam logic [POS_W-1:0] POS_SUBTYPE = 17'd2;
	localparam logic [POS_W-1:0] POS_LEN_HI  = 17'd4;
	localparam logic [POS_W-1:0] POS_LEN_LO  = 17'd5;
	localparam logic [POS_W-1:0] POS_PAYLOAD = 17'd6;

endpackage

### rtl/radio_module_reply_deframer_unit.sv
// Radio module reply deframer: top level, single module.
// Depends on rmrd_pkg for codes, marks and widths.
//
//  channel   | direction | tdata (low bit up)                          | tuser
//  s_axis    | in        | cmd[1:0], rx_byte[9:2], zero pad            | -
//  m_axis    | out       | payload_byte, payload_index, status,        | is_done
//            |           | event_code, frame_length, zero pad          |
//  cfg       | in        | index 0 timeout_ticks, index 1 event_mode   | -
//
// One transfer is taken every cycle unless m_axis stalls; each result passes
// through the input register, then the result register. Frame state is updated
// in the cycle the input register hands its item to the result register.
// arst_n clears all control and frame state and loads the register defaults.
// A stall on m_axis holds the result register and then the input register.
module radio_module_reply_deframer_unit #(
	parameter int MAX_PAYLOAD = rmrd_pkg::DEF_MAX_PAYLOAD
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [rmrd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rmrd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// cmd [1:0], rx_byte [9:2], zeros above
	input  logic [rmrd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// payload_byte [7:0], payload_index [15:8], status [18:16],
	// event_code [27:19], frame_length [43:28], zeros above
	output logic [rmrd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// is_done [0]
	output logic                              m_axis_tuser
);

	localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD);

	// configuration
	logic [rmrd_pkg::LEN_W-1:0] timeout_q;
	logic                       event_mode_q;

	// input register
	logic                          valid_s1;
	logic [rmrd_pkg::CMD_W-1:0]    cmd_s1;
	logic [rmrd_pkg::BYTE_W-1:0]   byte_s1;

	// frame state
	logic                          active_q;
	logic [rmrd_pkg::POS_W-1:0]    pos_q;
	logic [rmrd_pkg::BYTE_W-1:0]   type_q;
	logic [rmrd_pkg::BYTE_W-1:0]   subtype_q;
	logic [rmrd_pkg::BYTE_W-1:0]   len_hi_q;
	logic [rmrd_pkg::LEN_W-1:0]    len_q;
	logic [CNT_W-1:0]              count_q;
	logic [rmrd_pkg::LEN_W-1:0]    tick_q;

	// result register
	logic                          valid_s2;
	logic [rmrd_pkg::OUT_DATA_W-1:0] data_s2;
	logic                          done_s2;

	logic advance;

	// next-state and result logic
	logic                          active_d;
	logic [rmrd_pkg::POS_W-1:0]    pos_d;
	logic [rmrd_pkg::BYTE_W-1:0]   type_d;
	logic [rmrd_pkg::BYTE_W-1:0]   subtype_d;
	logic [rmrd_pkg::BYTE_W-1:0]   len_hi_d;
	logic [rmrd_pkg::LEN_W-1:0]    len_d;
	logic [CNT_W-1:0]              count_d;
	logic [rmrd_pkg::LEN_W-1:0]    tick_d;
	logic [rmrd_pkg::POS_W-1:0]    pos_eff;
	logic                          res_valid;
	logic                          res_done;
	logic [rmrd_pkg::BYTE_W-1:0]   res_byte;
	logic [rmrd_pkg::BYTE_W-1:0]   res_index;
	logic [rmrd_pkg::STATUS_W-1:0] res_status;
	logic [rmrd_pkg::EVENT_W-1:0]  res_event;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = data_s2;
	assign m_axis_tuser  = done_s2;

	always_comb begin
		active_d   = active_q;
		pos_d      = pos_q;
		type_d     = type_q;
		subtype_d  = subtype_q;
		len_hi_d   = len_hi_q;
		len_d      = len_q;
		count_d    = count_q;
		tick_d     = tick_q;
		pos_eff    = pos_q;
		res_valid  = 1'b0;
		res_done   = 1'b0;
		res_byte   = '0;
		res_index  = '0;
		res_status = rmrd_pkg::ST_OK;
		res_event  = '0;

		if (cmd_s1 == rmrd_pkg::CMD_START) begin
			pos_d     = '0;
			type_d    = '0;
			subtype_d = '0;
			len_hi_d  = '0;
			len_d     = '0;
			count_d   = '0;
			tick_d    = '0;
			active_d  = 1'b1;
		end else if (active_q && (cmd_s1 == rmrd_pkg::CMD_BYTE ||
				cmd_s1 == rmrd_pkg::CMD_TICK)) begin
			if (count_q >= CNT_MAX) begin
				res_valid  = 1'b1;
				res_done   = 1'b1;
				res_status = rmrd_pkg::ST_OVERFLOW;
				active_d   = 1'b0;
			end else if (cmd_s1 == rmrd_pkg::CMD_TICK) begin
				tick_d = tick_q + 16'd1;
				if (tick_d == '0 || tick_d >= timeout_q) begin
					res_valid  = 1'b1;
					res_done   = 1'b1;
					res_status = rmrd_pkg::ST_TIMEOUT;
					active_d   = 1'b0;
				end
			end else begin
				// a start mark restarts the frame and counts as header byte zero
				if (byte_s1 == rmrd_pkg::MARK_START) begin
					pos_d     = '0;
					type_d    = '0;
					subtype_d = '0;
					len_hi_d  = '0;
					len_d     = '0;
					count_d   = '0;
				end
				pos_eff = pos_d;
				if (pos_eff == rmrd_pkg::POS_TYPE)
					type_d = byte_s1;
				else if (pos_eff == rmrd_pkg::POS_SUBTYPE)
					subtype_d = byte_s1;
				else if (pos_eff == rmrd_pkg::POS_LEN_HI)
					len_hi_d = byte_s1;
				else if (pos_eff == rmrd_pkg::POS_LEN_LO)
					len_d = {len_hi_d, byte_s1};
				if (pos_eff != rmrd_pkg::POS_MAX)
					pos_d = pos_eff + 17'd1;

				if (pos_eff >= rmrd_pkg::POS_PAYLOAD &&
						rmrd_pkg::LEN_W'(count_d) < len_d) begin
					res_valid = 1'b1;
					res_byte  = byte_s1;
					res_index = rmrd_pkg::BYTE_W'(count_d);
					count_d   = count_d + CNT_W'(1);
				end else if (byte_s1 == rmrd_pkg::MARK_END &&
						pos_eff >= {1'b0, len_d} + rmrd_pkg::POS_PAYLOAD) begin
					res_valid = 1'b1;
					res_done  = 1'b1;
					active_d  = 1'b0;
					if (event_mode_q) begin
						if (type_d == rmrd_pkg::EVENT_TYPE)
							res_event = {1'b0, subtype_d} + 9'd1;
						else
							res_status = rmrd_pkg::ST_NO_EVENT;
					end else if (type_d == '0 && subtype_d == rmrd_pkg::REFUSE_SUBTYPE) begin
						res_status = rmrd_pkg::ST_REFUSED;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q    <= rmrd_pkg::TIMEOUT_RESET;
			event_mode_q <= 1'b0;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			active_q     <= 1'b0;
			pos_q        <= '0;
			type_q       <= '0;
			subtype_q    <= '0;
			len_hi_q     <= '0;
			len_q        <= '0;
			count_q      <= '0;
			tick_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					rmrd_pkg::REG_TIMEOUT:    timeout_q    <= cfg_data;
					rmrd_pkg::REG_EVENT_MODE: event_mode_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (advance) begin
				active_q  <= active_d;
				pos_q     <= pos_d;
				type_q    <= type_d;
				subtype_q <= subtype_d;
				len_hi_q  <= len_hi_d;
				len_q     <= len_d;
				count_q   <= count_d;
				tick_q    <= tick_d;
				valid_s2  <= res_valid;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1  <= s_axis_tdata[1:0];
			byte_s1 <= s_axis_tdata[9:2];
		end
		if (advance && res_valid) begin
			done_s2 <= res_done;
			data_s2 <= {4'd0, len_d, res_event, res_status, res_index, res_byte};
		end
	end

endmodule

### verif/radio_module_reply_deframer_unit_tb.sv
// Self-checking testbench for the radio module reply deframer top level.
// Needs rmrd_pkg and radio_module_reply_deframer_unit; frame stimulus, an in-bench
// deframer predictor and an in-order result check on the output stream.
module radio_module_reply_deframer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_PAY = rmrd_pkg::DEF_MAX_PAYLOAD;
	localparam logic [rmrd_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS = 15;

	typedef struct packed {
		logic                          done;
		logic [rmrd_pkg::BYTE_W-1:0]   pbyte;
		logic [rmrd_pkg::BYTE_W-1:0]   pidx;
		logic [rmrd_pkg::STATUS_W-1:0] status;
		logic [rmrd_pkg::EVENT_W-1:0]  evcode;
		logic [rmrd_pkg::LEN_W-1:0]    flen;
	} reply_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              cfg_wr_en = 1'b0;
	logic [rmrd_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
	logic [rmrd_pkg::CFG_DATA_W-1:0]   cfg_data = '0;
	logic                              s_axis_tvalid = 1'b0;
	logic                              s_axis_tready;
	logic [rmrd_pkg::IN_DATA_W-1:0]    s_axis_tdata = '0;
	logic                              m_axis_tvalid;
	logic                              m_axis_tready = 1'b0;
	logic [rmrd_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
	logic                              m_axis_tuser;

	// predictor copy of the block state and registers
	logic                              rx_active = 1'b0;
	logic [rmrd_pkg::POS_W-1:0]        rx_pos = '0;
	logic [rmrd_pkg::BYTE_W-1:0]       hdr_type = '0;
	logic [rmrd_pkg::BYTE_W-1:0]       hdr_subtype = '0;
	logic [rmrd_pkg::BYTE_W-1:0]       hdr_len_hi = '0;
	logic [rmrd_pkg::LEN_W-1:0]        pay_len = '0;
	int                                pay_count = 0;
	logic [rmrd_pkg::LEN_W-1:0]        tick_cnt = '0;
	logic [rmrd_pkg::LEN_W-1:0]        cfg_timeout = rmrd_pkg::TIMEOUT_RESET;
	logic                              cfg_event_mode = 1'b0;

	reply_t pending_replies[$];

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int hold_len = 0;
	int items_sent = 0;
	int mismatches = 0;
	int results_seen = 0;
	int ends_seen = 0;
	int cycle_count = 0;

	always #2 clk = ~clk;

	radio_module_reply_deframer_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	function automatic void clear_frame_state();
		rx_pos = '0;
		hdr_type = '0;
		hdr_subtype = '0;
		hdr_len_hi = '0;
		pay_len = '0;
		pay_count = 0;
	endfunction

	function automatic void push_end(input logic [rmrd_pkg::STATUS_W-1:0] st,
			input logic [rmrd_pkg::EVENT_W-1:0] ev);
		reply_t r;
		r = '0;
		r.done = 1'b1;
		r.status = st;
		r.evcode = ev;
		r.flen = pay_len;
		rx_active = 1'b0;
		pending_replies.push_back(r);
	endfunction

	// Advance the predicted deframer by one accepted transfer.
	function automatic void deframe_step(input logic [rmrd_pkg::CMD_W-1:0] cmd,
			input logic [rmrd_pkg::BYTE_W-1:0] rx);
		logic [rmrd_pkg::POS_W-1:0] p;
		reply_t r;
		if (cmd == rmrd_pkg::CMD_START) begin
			clear_frame_state();
			tick_cnt = '0;
			rx_active = 1'b1;
			return;
		end
		if ((cmd != rmrd_pkg::CMD_BYTE && cmd != rmrd_pkg::CMD_TICK) || !rx_active)
			return;
		if (pay_count >= MAX_PAY) begin
			push_end(rmrd_pkg::ST_OVERFLOW, '0);
			return;
		end
		if (cmd == rmrd_pkg::CMD_TICK) begin
			tick_cnt = tick_cnt + 1'b1;
			if (tick_cnt == '0 || tick_cnt >= cfg_timeout)
				push_end(rmrd_pkg::ST_TIMEOUT, '0);
			return;
		end
		if (rx == rmrd_pkg::MARK_START)
			clear_frame_state();
		p = rx_pos;
		case (p)
			rmrd_pkg::POS_TYPE: hdr_type = rx;
			rmrd_pkg::POS_SUBTYPE: hdr_subtype = rx;
			rmrd_pkg::POS_LEN_HI: hdr_len_hi = rx;
			rmrd_pkg::POS_LEN_LO: pay_len = {hdr_len_hi, rx};
			default: ;
		endcase
		if (rx_pos != rmrd_pkg::POS_MAX)
			rx_pos = rx_pos + 1'b1;
		if (p >= rmrd_pkg::POS_PAYLOAD && pay_count < pay_len) begin
			r = '0;
			r.pbyte = rx;
			r.pidx = pay_count[7:0];
			r.flen = pay_len;
			pending_replies.push_back(r);
			pay_count++;
			return;
		end
		if (rx == rmrd_pkg::MARK_END &&
				p >= rmrd_pkg::POS_W'(pay_len) + rmrd_pkg::POS_PAYLOAD) begin
			if (cfg_event_mode) begin
				if (hdr_type == rmrd_pkg::EVENT_TYPE)
					push_end(rmrd_pkg::ST_OK, rmrd_pkg::EVENT_W'(hdr_subtype) + 1'b1);
				else
					push_end(rmrd_pkg::ST_NO_EVENT, '0);
			end else if (hdr_type == '0 && hdr_subtype == rmrd_pkg::REFUSE_SUBTYPE) begin
				push_end(rmrd_pkg::ST_REFUSED, '0);
			end else begin
				push_end(rmrd_pkg::ST_OK, '0);
			end
		end
	endfunction

	function automatic void report_mismatch(input string what, input reply_t want,
			input reply_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t %s: want done=%0d byte=%02h idx=%0d st=%0d ev=%0d len=%0d",
				$realtime, what, want.done, want.pbyte, want.pidx, want.status,
				want.evcode, want.flen);
			$display("    got done=%0d byte=%02h idx=%0d st=%0d ev=%0d len=%0d",
				got.done, got.pbyte, got.pidx, got.status, got.evcode, got.flen);
		end
	endfunction

	// Offer one item, hold it until the transfer, then predict its result.
	task automatic send_item(input logic [rmrd_pkg::CMD_W-1:0] cmd,
			input logic [rmrd_pkg::BYTE_W-1:0] rx);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= rmrd_pkg::IN_DATA_W'({rx, cmd});
		do @(posedge clk); while (!s_axis_tready);
		deframe_step(cmd, rx);
		items_sent++;
	endtask

	task automatic send_byte(input logic [rmrd_pkg::BYTE_W-1:0] rx);
		send_item(rmrd_pkg::CMD_BYTE, rx);
	endtask

	task automatic send_tick();
		send_item(rmrd_pkg::CMD_TICK, 8'($urandom));
	endtask

	task automatic send_start();
		send_item(rmrd_pkg::CMD_START, 8'($urandom));
	endtask

	task automatic send_header(input logic [rmrd_pkg::BYTE_W-1:0] ftype,
			input logic [rmrd_pkg::BYTE_W-1:0] fsub,
			input logic [rmrd_pkg::LEN_W-1:0] len);
		send_byte(rmrd_pkg::MARK_START);
		send_byte(ftype);
		send_byte(fsub);
		send_byte(8'($urandom));
		send_byte(len[15:8]);
		send_byte(len[7:0]);
	endtask

	// Drop valid, wait for every predicted result, then let the pipe empty.
	task automatic wait_quiet();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [rmrd_pkg::CFG_IDX_W-1:0] idx,
			input logic [rmrd_pkg::CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		if (idx == rmrd_pkg::REG_TIMEOUT)
			cfg_timeout = data;
		else
			cfg_event_mode = data[0];
	endtask

	task automatic set_config(input logic [rmrd_pkg::LEN_W-1:0] tmo, input logic ev);
		wait_quiet();
		write_reg(rmrd_pkg::REG_TIMEOUT, tmo);
		write_reg(rmrd_pkg::REG_EVENT_MODE, rmrd_pkg::CFG_DATA_W'(ev));
	endtask

	task automatic test_idle_input();
		// block is not active after reset: all items before the start command are dropped
		send_byte(rmrd_pkg::MARK_START);
		send_byte(8'h00);
		send_item(rmrd_pkg::CMD_TICK, 8'hFF);
		send_byte(rmrd_pkg::MARK_END);
		send_item(CMD_UNUSED, rmrd_pkg::MARK_START);
		send_start();
		send_item(CMD_UNUSED, rmrd_pkg::MARK_END);
		send_header(8'h00, 8'h01, 16'd0);
		send_byte(rmrd_pkg::MARK_END);
		send_byte(rmrd_pkg::MARK_END);
	endtask

	task automatic test_command_reply();
		send_start();
		send_header(8'h00, rmrd_pkg::REFUSE_SUBTYPE, 16'd2);
		send_byte(rmrd_pkg::MARK_END);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(rmrd_pkg::MARK_END);
		// end mark taken as the type byte
		send_start();
		send_header(rmrd_pkg::MARK_END, rmrd_pkg::REFUSE_SUBTYPE, 16'd0);
		send_byte(rmrd_pkg::MARK_END);
	endtask

	task automatic test_event_reply();
		set_config(rmrd_pkg::TIMEOUT_RESET, 1'b1);
		send_start();
		send_header(rmrd_pkg::EVENT_TYPE, 8'hFF, 16'd1);
		send_byte(8'hAB);
		send_byte(rmrd_pkg::MARK_END);
		send_start();
		send_header(rmrd_pkg::EVENT_TYPE, 8'h00, 16'd0);
		send_byte(rmrd_pkg::MARK_END);
		send_start();
		send_header(8'h00, rmrd_pkg::REFUSE_SUBTYPE, 16'd0);
		send_byte(rmrd_pkg::MARK_END);
		set_config(rmrd_pkg::TIMEOUT_RESET, 1'b0);
	endtask

	task automatic test_restart_mark();
		send_start();
		send_header(8'h00, rmrd_pkg::REFUSE_SUBTYPE, 16'd5);
		send_byte(8'h11);
		send_byte(8'h22);
		// a fresh start mark mid-payload clears length and header
		send_header(8'h05, 8'h00, 16'd1);
		send_byte(8'h33);
		send_byte(rmrd_pkg::MARK_END);
	endtask

	task automatic test_timeout();
		set_config(16'd1, 1'b0);
		send_start();
		send_tick();
		send_tick();
		set_config(16'd3, 1'b0);
		send_start();
		send_tick();
		send_header(8'h00, 8'h00, 16'd4);
		send_byte(8'h5A);
		send_tick();
		send_tick();
	endtask

	task automatic test_overflow();
		set_config(rmrd_pkg::TIMEOUT_RESET, 1'b0);
		send_start();
		send_header(8'h00, 8'h00, 16'd256);
		repeat (MAX_PAY) send_byte(8'($urandom_range(0, 8'hFD)));
		// a full payload turns this end mark into an overflow
		send_byte(rmrd_pkg::MARK_END);
	endtask

	task automatic test_backpressure();
		wait_quiet();
		send_start();
		hold_len = 300;
		send_header(8'h00, 8'h00, 16'd12);
		repeat (12) send_byte(8'($urandom_range(0, 8'hFD)));
		send_byte(rmrd_pkg::MARK_END);
		wait_quiet();
	endtask

	task automatic random_exchange();
		int unsigned pick;
		int unsigned len;
		logic [rmrd_pkg::BYTE_W-1:0] ftype;
		logic [rmrd_pkg::BYTE_W-1:0] fsub;
		pick = $urandom_range(99);
		if (pick < 8) begin
			repeat ($urandom_range(1, 6))
				send_item(rmrd_pkg::CMD_W'($urandom_range(3)), 8'($urandom));
			return;
		end
		send_start();
		case ($urandom_range(2))
			0: ftype = 8'h00;
			1: ftype = rmrd_pkg::EVENT_TYPE;
			default: ftype = 8'($urandom);
		endcase
		case ($urandom_range(2))
			0: fsub = rmrd_pkg::REFUSE_SUBTYPE;
			1: fsub = 8'hFF;
			default: fsub = 8'($urandom);
		endcase
		len = ($urandom_range(19) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
		send_header(ftype, fsub, rmrd_pkg::LEN_W'(len));
		repeat (len) begin
			if ($urandom_range(9) == 0)
				send_tick();
			send_byte(($urandom_range(99) < 2) ? rmrd_pkg::MARK_START : 8'($urandom));
		end
		// leave some frames unfinished
		if (pick < 20)
			return;
		repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
		send_byte(rmrd_pkg::MARK_END);
	endtask

	task automatic test_random_traffic();
		int src_plan[4] = '{0, 48, 0, 37};
		int sink_plan[4] = '{0, 0, 48, 37};
		logic [rmrd_pkg::LEN_W-1:0] tmo_plan[4] =
			'{rmrd_pkg::TIMEOUT_RESET, 16'd9, 16'hFFFF, 16'd3};
		logic ev_plan[4] = '{1'b0, 1'b1, 1'b0, 1'b1};
		int ph;
		int target;
		for (ph = 0; ph < 4; ph++) begin
			set_config(tmo_plan[ph], ev_plan[ph]);
			src_idle_pct = src_plan[ph];
			sink_stall_pct = sink_plan[ph];
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target)
				random_exchange();
		end
		wait_quiet();
		src_idle_pct = 0;
		sink_stall_pct = 0;
	endtask

	// Receiver: random stalls, or a long hold-off when a test asks for one.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : check_results
		reply_t got;
		reply_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.done = m_axis_tuser;
			got.pbyte = m_axis_tdata[7:0];
			got.pidx = m_axis_tdata[15:8];
			got.status = m_axis_tdata[18:16];
			got.evcode = m_axis_tdata[27:19];
			got.flen = m_axis_tdata[43:28];
			results_seen++;
			if (got.done)
				ends_seen++;
			if (pending_replies.size() == 0) begin
				report_mismatch("unexpected result", '0, got);
			end else begin
				want = pending_replies.pop_front();
				if (got != want)
					report_mismatch("mismatch", want, got);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_input();
		test_command_reply();
		test_event_reply();
		test_restart_mark();
		test_timeout();
		test_overflow();
		test_backpressure();
		test_random_traffic();
		wait_quiet();
		mismatches += pending_replies.size();
		$display("covered %0d input transfers, %0d results checked, %0d of them end of frame",
			items_sent, results_seen, ends_seen);
		$display("both check modes, timeouts 1 to 65535, overflow, restart and a long stall");
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### radio_module_reply_deframer_unit.f
rtl/rmrd_pkg.sv
rtl/radio_module_reply_deframer_unit.sv
verif/radio_module_reply_deframer_unit_tb.sv
